/* rtl/pht_pkg.sv */
package pht_pkg;

  // Pool geometry. A list pointer needs one extra code for the null link.
  localparam int SLOTS = 16;
  localparam int IDX_W = $clog2(SLOTS);
  localparam int PTR_W = $clog2(SLOTS + 1);
  localparam logic [PTR_W-1:0] NIL = PTR_W'(SLOTS);

  // Field widths of one input word and one result word.
  localparam int TAG_W  = 32;
  localparam int CTX_W  = 32;
  localparam int PRIO_W = 32;

  // Action codes of an input word.
  localparam logic [1:0] ACT_REG = 2'd0;
  localparam logic [1:0] ACT_REL = 2'd1;
  localparam logic [1:0] ACT_DSP = 2'd2;

  // Status codes of a result word.
  localparam logic [2:0] STS_OK       = 3'd0;
  localparam logic [2:0] STS_INTR     = 3'd1;
  localparam logic [2:0] STS_NO_SPACE = 3'd2;
  localparam logic [2:0] STS_EXISTS   = 3'd3;
  localparam logic [2:0] STS_NOT_FND  = 3'd4;
  localparam logic [2:0] STS_ENTRY    = 3'd5;
  localparam logic [2:0] STS_EMPTY    = 3'd6;

  // Payload of one slot in the data memory.
  typedef struct packed {
    logic [TAG_W-1:0]         handler;
    logic [CTX_W-1:0]         context_word;
    logic signed [PRIO_W-1:0] prio;
  } slot_t;

  // Sequencer states, one-hot.
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_WALK = 4'b0010,
    ST_INS  = 4'b0100,
    ST_LINK = 4'b1000
  } state_t;

endpackage

/* rtl/priority_handler_table_core.sv */
// Interrupt-context and pool-full words, and release or dispatch words on an empty list, answer in
// the cycle after start; the unused action code gives no word. Other words walk the list one slot
// per cycle: release stops at the tag (or the list end), register stops at the tag or walks the
// whole list, then fills the new slot and links its predecessor; dispatch gives one word per cycle.
// The core takes one input word at a time and stays busy until it is through with it.
// Reset (synchronous, rst_n low) empties both lists and frees all slots; no receiver stall.
module priority_handler_table_core
  import pht_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               in_action,
  input  logic                     in_list_sel,
  input  logic signed [PRIO_W-1:0] in_prio,
  input  logic [TAG_W-1:0]         in_handler_tag,
  input  logic [CTX_W-1:0]         in_context_word,
  input  logic                     in_in_interrupt,
  output logic                     out_valid,
  output logic [2:0]               out_status,
  output logic [TAG_W-1:0]         out_handler,
  output logic [CTX_W-1:0]         out_context,
  output logic                     out_first_tick,
  output logic                     out_last
);

  // Slot memories: payload and next link, one synchronous read port each.
  slot_t            data_mem [SLOTS];
  logic [PTR_W-1:0] next_mem [SLOTS];

  state_t state_r, state_nxt;
  logic [PTR_W-1:0] head_r [2];
  logic [PTR_W-1:0] head_nxt [2];
  logic [SLOTS-1:0] free_r, free_nxt;
  logic seen_r, seen_nxt;
  logic out_valid_r, out_valid_nxt;

  // Walk context and the latched input word.
  logic [PTR_W-1:0] cur_r, cur_nxt;
  logic [PTR_W-1:0] prev_r, prev_nxt;
  logic [PTR_W-1:0] insn_r, insn_nxt;
  logic [IDX_W-1:0] node_r, node_nxt;
  logic found_r, found_nxt;
  logic ft_r, ft_nxt;
  logic [1:0] op_r, op_nxt;
  logic ls_r, ls_nxt;
  logic signed [PRIO_W-1:0] prio_r, prio_nxt;
  logic [TAG_W-1:0] tag_r, tag_nxt;
  logic [CTX_W-1:0] ctx_r, ctx_nxt;

  // Result word registers.
  logic [2:0]       out_status_r, out_status_nxt;
  logic [TAG_W-1:0] out_handler_r, out_handler_nxt;
  logic [CTX_W-1:0] out_context_r, out_context_nxt;
  logic             out_first_tick_r, out_first_tick_nxt;
  logic             out_last_r, out_last_nxt;

  // Memory port signals.
  logic [IDX_W-1:0] rd_addr;
  slot_t            rd_slot_r;
  logic [PTR_W-1:0] rd_next_r;
  logic             dat_we;
  logic             nx_we;
  logic [IDX_W-1:0] nx_waddr;
  logic [PTR_W-1:0] nx_wdata;
  logic [IDX_W-1:0] low_free;
  logic             ft_now;

  // Lowest-numbered free slot.
  always_comb begin
    low_free = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (free_r[i]) begin
        low_free = IDX_W'(i);
      end
    end
  end

  // Slot memories: registered read, single write per memory.
  always_ff @(posedge clk) begin
    rd_slot_r <= data_mem[rd_addr];
    rd_next_r <= next_mem[rd_addr];
    if (dat_we) begin
      data_mem[low_free] <= '{handler: tag_r, context_word: ctx_r, prio: prio_r};
    end
    if (nx_we) begin
      next_mem[nx_waddr] <= nx_wdata;
    end
  end

  // Sequencer: accepts a word, walks the list and links or unlinks slots.
  always_comb begin
    state_nxt          = state_r;
    head_nxt           = head_r;
    free_nxt           = free_r;
    seen_nxt           = seen_r;
    cur_nxt            = cur_r;
    prev_nxt           = prev_r;
    insn_nxt           = insn_r;
    node_nxt           = node_r;
    found_nxt          = found_r;
    ft_nxt             = ft_r;
    op_nxt             = op_r;
    ls_nxt             = ls_r;
    prio_nxt           = prio_r;
    tag_nxt            = tag_r;
    ctx_nxt            = ctx_r;
    out_valid_nxt      = 1'b0;
    out_status_nxt     = STS_OK;
    out_handler_nxt    = '0;
    out_context_nxt    = '0;
    out_first_tick_nxt = 1'b0;
    out_last_nxt       = 1'b1;
    rd_addr            = head_r[in_list_sel][IDX_W-1:0];
    dat_we             = 1'b0;
    nx_we              = 1'b0;
    nx_waddr           = prev_r[IDX_W-1:0];
    nx_wdata           = NIL;
    ft_now             = !in_list_sel && !seen_r;

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          op_nxt    = in_action;
          ls_nxt    = in_list_sel;
          prio_nxt  = in_prio;
          tag_nxt   = in_handler_tag;
          ctx_nxt   = in_context_word;
          cur_nxt   = head_r[in_list_sel];
          prev_nxt  = NIL;
          insn_nxt  = NIL;
          found_nxt = 1'b0;
          priority case (in_action)
            ACT_REG: begin
              if (in_in_interrupt) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = STS_INTR;
              end else if (free_r == '0) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = STS_NO_SPACE;
              end else if (head_r[in_list_sel] == NIL) begin
                state_nxt = ST_INS;
              end else begin
                state_nxt = ST_WALK;
              end
            end
            ACT_REL: begin
              if (in_in_interrupt) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = STS_INTR;
              end else if (head_r[in_list_sel] == NIL) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = STS_NOT_FND;
              end else begin
                state_nxt = ST_WALK;
              end
            end
            ACT_DSP: begin
              ft_nxt = ft_now;
              if (ft_now) begin
                seen_nxt = 1'b1;
              end
              if (head_r[in_list_sel] == NIL) begin
                out_valid_nxt      = 1'b1;
                out_status_nxt     = STS_EMPTY;
                out_first_tick_nxt = ft_now;
              end else begin
                state_nxt = ST_WALK;
              end
            end
            default: begin
              // The unused action code is dropped without a result.
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end

      ST_WALK: begin
        // Data for cur_r is on the read port; fetch its successor meanwhile.
        rd_addr = rd_next_r[IDX_W-1:0];
        cur_nxt = rd_next_r;
        priority case (op_r)
          ACT_DSP: begin
            out_valid_nxt      = 1'b1;
            out_status_nxt     = STS_ENTRY;
            out_handler_nxt    = rd_slot_r.handler;
            out_context_nxt    = rd_slot_r.context_word;
            out_first_tick_nxt = ft_r;
            out_last_nxt       = (rd_next_r == NIL);
            if (rd_next_r == NIL) begin
              state_nxt = ST_IDLE;
            end
          end
          ACT_REL: begin
            if (rd_slot_r.handler == tag_r) begin
              // Unlink the slot and hand it back to the pool.
              if (prev_r == NIL) begin
                head_nxt[ls_r] = rd_next_r;
              end else begin
                nx_we    = 1'b1;
                nx_waddr = prev_r[IDX_W-1:0];
                nx_wdata = rd_next_r;
              end
              free_nxt[cur_r[IDX_W-1:0]] = 1'b1;
              out_valid_nxt  = 1'b1;
              out_status_nxt = STS_OK;
              state_nxt      = ST_IDLE;
            end else begin
              prev_nxt = cur_r;
              if (rd_next_r == NIL) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = STS_NOT_FND;
                state_nxt      = ST_IDLE;
              end
            end
          end
          default: begin
            // Register: check the whole list for the tag and note where the
            // new entry goes, after every entry of lower or equal priority.
            if (rd_slot_r.handler == tag_r) begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = STS_EXISTS;
              state_nxt      = ST_IDLE;
            end else begin
              if (!found_r) begin
                if (rd_slot_r.prio <= prio_r) begin
                  prev_nxt = cur_r;
                end else begin
                  found_nxt = 1'b1;
                  insn_nxt  = cur_r;
                end
              end
              if (rd_next_r == NIL) begin
                state_nxt = ST_INS;
              end
            end
          end
        endcase
      end

      ST_INS: begin
        // Fill the lowest free slot and point it at its successor.
        dat_we   = 1'b1;
        nx_we    = 1'b1;
        nx_waddr = low_free;
        nx_wdata = insn_r;
        node_nxt = low_free;
        free_nxt[low_free] = 1'b0;
        if (prev_r == NIL) begin
          head_nxt[ls_r] = PTR_W'(low_free);
          out_valid_nxt  = 1'b1;
          out_status_nxt = STS_OK;
          state_nxt      = ST_IDLE;
        end else begin
          state_nxt = ST_LINK;
        end
      end

      ST_LINK: begin
        // Point the predecessor at the new slot.
        nx_we          = 1'b1;
        nx_waddr       = prev_r[IDX_W-1:0];
        nx_wdata       = PTR_W'(node_r);
        out_valid_nxt  = 1'b1;
        out_status_nxt = STS_OK;
        state_nxt      = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r[0]   <= NIL;
      head_r[1]   <= NIL;
      free_r      <= '1;
      seen_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      free_r      <= free_nxt;
      seen_r      <= seen_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    cur_r            <= cur_nxt;
    prev_r           <= prev_nxt;
    insn_r           <= insn_nxt;
    node_r           <= node_nxt;
    found_r          <= found_nxt;
    ft_r             <= ft_nxt;
    op_r             <= op_nxt;
    ls_r             <= ls_nxt;
    prio_r           <= prio_nxt;
    tag_r            <= tag_nxt;
    ctx_r            <= ctx_nxt;
    out_status_r     <= out_status_nxt;
    out_handler_r    <= out_handler_nxt;
    out_context_r    <= out_context_nxt;
    out_first_tick_r <= out_first_tick_nxt;
    out_last_r       <= out_last_nxt;
  end

  assign busy           = (state_r != ST_IDLE);
  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_handler    = out_handler_r;
  assign out_context    = out_context_r;
  assign out_first_tick = out_first_tick_r;
  assign out_last       = out_last_r;

  // An insert only starts when the pool still has a free slot.
  a_ins_has_space: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_INS) |-> (free_r != '0))
    else $error("insert started with an empty pool");

  // The link cycle always has a predecessor to patch.
  a_link_has_prev: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LINK) |-> (prev_r != NIL))
    else $error("link cycle without predecessor");

  // A dispatch word that is not the last is followed at once by another.
  a_dispatch_burst: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |=> out_valid)
    else $error("gap inside a dispatch burst");

endmodule
